// ===== rtl/dta_pkg.sv =====
// ----------------------------------------------------------------------------
// dta_pkg: shared definitions for the dining table arbiter
// Seat count, phase and request codes, cell commands and the control and
// status structs that travel between the sequencer and the cell row.
// ----------------------------------------------------------------------------
package dta_pkg;

  localparam int SEATS  = 8;
  localparam int SEAT_W = $clog2(SEATS);

  typedef logic [SEAT_W-1:0] sidx_t;

  typedef enum logic [1:0] {
    PH_THINK  = 2'd0,
    PH_HUNGRY = 2'd1,
    PH_EAT    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    FN_SIT    = 2'd0,
    FN_HUNGRY = 2'd1,
    FN_DONE   = 2'd2,
    FN_LEAVE  = 2'd3
  } func_t;

  localparam logic [2:0] K_SEATED = 3'd0;
  localparam logic [2:0] K_FULL   = 3'd1;
  localparam logic [2:0] K_GRANT  = 3'd2;
  localparam logic [2:0] K_ACK    = 3'd3;
  localparam logic [2:0] K_BYE    = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SIT,
    CMD_HUNGRY,
    CMD_THINK,
    CMD_TEST,
    CMD_LEAVE
  } cmd_t;

  // What a cell shows to its two ring neighbors.
  typedef struct packed {
    logic taken;
    logic eat;
  } cell_link_t;

  // Priority chain for the seat search, passed from cell to cell.
  typedef struct packed {
    logic ideal;
    logic free;
  } chain_t;

  typedef struct packed {
    cmd_t  cmd;
    sidx_t idx;
  } row_cmd_t;

  typedef struct packed {
    logic             found;
    sidx_t            pick;
    logic             grant;
    logic [SEATS-1:0] eat;
  } row_stat_t;

endpackage

// ===== rtl/dta_cell.sv =====
// ----------------------------------------------------------------------------
// dta_cell: one seat of the table
// Holds the seat's taken bit and phase, takes part in the seat search chain
// and decides its own eat grant from its neighbors' phases.
// ----------------------------------------------------------------------------
module dta_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  dta_pkg::cmd_t       cmd,
  input  logic                sel,
  input  dta_pkg::cell_link_t nb_l,
  input  dta_pkg::cell_link_t nb_r,
  input  dta_pkg::chain_t     chain_in,
  input  logic                any_ideal,
  output dta_pkg::cell_link_t self_o,
  output dta_pkg::chain_t     chain_out,
  output logic                pick_o,
  output logic                grant_o
);

  logic             taken_r, taken_nxt;
  dta_pkg::phase_t  phase_r, phase_nxt;
  logic             ideal_here, free_here, forks_free;

  assign free_here  = !taken_r;
  assign ideal_here = !taken_r && !nb_l.taken && !nb_r.taken;
  assign forks_free = !nb_l.eat && !nb_r.eat;

  assign chain_out.ideal = chain_in.ideal || ideal_here;
  assign chain_out.free  = chain_in.free || free_here;
  assign pick_o = any_ideal ? (ideal_here && !chain_in.ideal) : (free_here && !chain_in.free);

  assign self_o.taken = taken_r;
  assign self_o.eat   = (phase_r == dta_pkg::PH_EAT);

  always_comb begin
    taken_nxt = taken_r;
    phase_nxt = phase_r;
    grant_o   = 1'b0;
    case (cmd)
      dta_pkg::CMD_SIT: begin
        if (pick_o) taken_nxt = 1'b1;
      end
      dta_pkg::CMD_HUNGRY: begin
        // The seat turns hungry and is tested at once.
        if (sel) begin
          grant_o   = forks_free;
          phase_nxt = forks_free ? dta_pkg::PH_EAT : dta_pkg::PH_HUNGRY;
        end
      end
      dta_pkg::CMD_THINK: begin
        if (sel) phase_nxt = dta_pkg::PH_THINK;
      end
      dta_pkg::CMD_TEST: begin
        if (sel && phase_r == dta_pkg::PH_HUNGRY && forks_free) begin
          grant_o   = 1'b1;
          phase_nxt = dta_pkg::PH_EAT;
        end
      end
      dta_pkg::CMD_LEAVE: begin
        if (sel) taken_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
      phase_r <= dta_pkg::PH_THINK;
    end else begin
      taken_r <= taken_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/dta_row.sv =====
// ----------------------------------------------------------------------------
// dta_row: the ring of seat cells
// Wires each cell to its ring neighbors, runs the seat search chain from
// seat 0 upward and gathers the grant and the chosen seat index.
// ----------------------------------------------------------------------------
module dta_row (
  input  logic               clk,
  input  logic               rst_n,
  input  dta_pkg::row_cmd_t  cmd,
  output dta_pkg::row_stat_t stat
);

  dta_pkg::cell_link_t         link [dta_pkg::SEATS];
  dta_pkg::chain_t             chain_c [dta_pkg::SEATS+1];
  logic [dta_pkg::SEATS-1:0]   pick, grant;
  dta_pkg::sidx_t              pick_idx;

  assign chain_c[0] = '0;

  for (genvar i = 0; i < dta_pkg::SEATS; i++) begin : g_cell
    localparam int L = (i + dta_pkg::SEATS - 1) % dta_pkg::SEATS;
    localparam int R = (i + 1) % dta_pkg::SEATS;

    dta_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd.cmd),
      .sel       (cmd.idx == dta_pkg::SEAT_W'(i)),
      .nb_l      (link[L]),
      .nb_r      (link[R]),
      .chain_in  (chain_c[i]),
      .any_ideal (chain_c[dta_pkg::SEATS].ideal),
      .self_o    (link[i]),
      .chain_out (chain_c[i+1]),
      .pick_o    (pick[i]),
      .grant_o   (grant[i])
    );

    assign stat.eat[i] = link[i].eat;
  end

  assign stat.found = chain_c[dta_pkg::SEATS].free;
  assign stat.grant = |grant;

  // Only one cell picks, so OR-ing the indexes encodes it.
  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < dta_pkg::SEATS; i++) begin
      if (pick[i]) pick_idx = pick_idx | dta_pkg::SEAT_W'(i);
    end
  end

  assign stat.pick = pick_idx;

endmodule

// ===== rtl/dining_table_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// dining_table_arbiter_top: seat and fork arbiter for a ring of seats
// Each request word is taken in idle and then runs one sequencer step for
// each command that it needs. Done eating steps through clearing the seat,
// testing the left neighbor, testing the right neighbor, then acknowledging.
// A request other than sit with a seat outside the table is dropped in its
// accept cycle. The sequencer issues one command per cycle to the cell row
// and waits whenever the output word is still held by a stalled receiver.
// ----------------------------------------------------------------------------
//
// The table is a row of cells, one per seat, each holding its taken bit and
// its think/hungry/eat phase. A sit word is answered with the lowest free
// seat whose two neighbors are also free, else the lowest free seat, else a
// table-full word with seat 0. A hungry word grants eating at once when
// neither neighbor eats and otherwise stays silent; the grant is sent later
// as an extra result word of a neighbor's done-eating request. Those grant
// words carry last = 0, and the done acknowledge that follows them carries
// last = 1. Leave frees the seat and keeps its phase. Results leave through
// an output register, so a finished word can wait for the receiver while the
// block goes back to idle and takes the next request.
module dining_table_arbiter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [2:0] in_seat,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [2:0] out_seat_out,
  output logic       out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TEST_L,
    S_TEST_R,
    S_ACK
  } state_t;

  state_t              state_r, state_nxt;
  dta_pkg::func_t      func_r, func_nxt;
  dta_pkg::sidx_t      sidx_r, sidx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_kind_r, out_kind_nxt;
  logic [2:0]          out_seat_r, out_seat_nxt;
  logic                out_last_r, out_last_nxt;

  dta_pkg::row_cmd_t   row_cmd;
  dta_pkg::row_stat_t  row_stat;
  dta_pkg::sidx_t      lidx, ridx;
  logic                out_free, load, in_range;
  logic [dta_pkg::SEATS-1:0] eat_rot;

  dta_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (row_cmd),
    .stat  (row_stat)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = (32'(in_seat) < dta_pkg::SEATS);

  // Ring neighbors of the requesting seat.
  assign lidx = (sidx_r == '0) ? dta_pkg::sidx_t'(dta_pkg::SEATS - 1)
                               : sidx_r - dta_pkg::sidx_t'(1);
  assign ridx = (sidx_r == dta_pkg::sidx_t'(dta_pkg::SEATS - 1)) ? '0
                               : sidx_r + dta_pkg::sidx_t'(1);

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    sidx_nxt     = sidx_r;
    row_cmd.cmd  = dta_pkg::CMD_NONE;
    row_cmd.idx  = sidx_r;
    load         = 1'b0;
    out_kind_nxt = out_kind_r;
    out_seat_nxt = out_seat_r;
    out_last_nxt = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt = dta_pkg::func_t'(in_func);
          sidx_nxt = dta_pkg::sidx_t'(in_seat);
          // Requests other than sit for a seat beyond the table are dropped here.
          if (dta_pkg::func_t'(in_func) == dta_pkg::FN_SIT || in_range) state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          dta_pkg::FN_SIT: begin
            if (out_free) begin
              row_cmd.cmd  = dta_pkg::CMD_SIT;
              load         = 1'b1;
              out_kind_nxt = row_stat.found ? dta_pkg::K_SEATED : dta_pkg::K_FULL;
              out_seat_nxt = row_stat.found ? 3'(row_stat.pick) : 3'd0;
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          dta_pkg::FN_HUNGRY: begin
            if (out_free) begin
              row_cmd.cmd  = dta_pkg::CMD_HUNGRY;
              load         = row_stat.grant;
              out_kind_nxt = dta_pkg::K_GRANT;
              out_seat_nxt = 3'(sidx_r);
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          dta_pkg::FN_DONE: begin
            row_cmd.cmd = dta_pkg::CMD_THINK;
            state_nxt   = S_TEST_L;
          end
          dta_pkg::FN_LEAVE: begin
            if (out_free) begin
              row_cmd.cmd  = dta_pkg::CMD_LEAVE;
              load         = 1'b1;
              out_kind_nxt = dta_pkg::K_BYE;
              out_seat_nxt = 3'(sidx_r);
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_TEST_L: begin
        if (out_free) begin
          row_cmd.cmd  = dta_pkg::CMD_TEST;
          row_cmd.idx  = lidx;
          load         = row_stat.grant;
          out_kind_nxt = dta_pkg::K_GRANT;
          out_seat_nxt = 3'(lidx);
          out_last_nxt = 1'b0;
          state_nxt    = S_TEST_R;
        end
      end
      S_TEST_R: begin
        // The right test sees a grant just made to the left neighbor.
        if (out_free) begin
          row_cmd.cmd  = dta_pkg::CMD_TEST;
          row_cmd.idx  = ridx;
          load         = row_stat.grant;
          out_kind_nxt = dta_pkg::K_GRANT;
          out_seat_nxt = 3'(ridx);
          out_last_nxt = 1'b0;
          state_nxt    = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          load         = 1'b1;
          out_kind_nxt = dta_pkg::K_ACK;
          out_seat_nxt = 3'(sidx_r);
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      sidx_r      <= sidx_nxt;
      if (load) begin
        out_kind_r <= out_kind_nxt;
        out_seat_r <= out_seat_nxt;
        out_last_r <= out_last_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_seat_out = out_seat_r;
  assign out_last     = out_last_r;

  // Each seat's right neighbor's eat bit, lined up with the seat itself.
  assign eat_rot = {row_stat.eat[0], row_stat.eat[dta_pkg::SEATS-1:1]};

  // Two neighbors never eat at the same time: they would share a fork.
  a_fork_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (row_stat.eat & eat_rot) == '0)
    else $error("neighboring seats eat at once");

  // Only grants from a done-eating request come before the final word.
  a_not_last_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> out_kind == dta_pkg::K_GRANT)
    else $error("non-final result that is not a grant");

  // A table-full word always names seat 0.
  a_full_seat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dta_pkg::K_FULL) |-> out_seat_out == 3'd0)
    else $error("table-full word with a seat");

  // An accepted request word holds off the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func == dta_pkg::FN_SIT || 32'(in_seat) < dta_pkg::SEATS))
      |=> in_stall)
    else $error("input not held off after a request");

endmodule
